### rtl/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

### rtl/rcbp_pkg.sv
// types and constants for the reference counted buffer pool
`timescale 1ns / 1ps

package rcbp_pkg;

   // pool geometry
   localparam int BUF_COUNT  = 63;
   localparam int RING_SLOTS = BUF_COUNT + 1;
   localparam int INDEX_W    = 6;
   localparam int SLOT_W     = $clog2(RING_SLOTS);
   localparam int LEVEL_W    = $clog2(RING_SLOTS);
   localparam int FILL_W     = $clog2(RING_SLOTS + 1);
   localparam int REF_AW     = $clog2(BUF_COUNT);
   localparam int KIND_W     = 2;
   localparam int STATUS_W   = 3;

   // operation codes
   typedef enum logic [KIND_W-1:0] {
      KIND_ALLOC = 2'd0,
      KIND_FREE  = 2'd1,
      KIND_SHARE = 2'd2
   } kind_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 3'd0,
      STATUS_EMPTY = 3'd1,
      STATUS_HELD  = 3'd2,
      STATUS_ZERO  = 3'd3,
      STATUS_SAT   = 3'd4
   } status_type;

   // commands into the free ring
   typedef struct packed {
      logic               pop;
      logic               push;
      logic [INDEX_W-1:0] push_index;
   } ring_ctl_type;

   // free ring status
   typedef struct packed {
      logic [INDEX_W-1:0] head_index;
      logic [LEVEL_W-1:0] level;
   } ring_stat_type;

   // ring slot advance with wrap
   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] slot);
      logic [SLOT_W-1:0] nxt;
      if (slot == SLOT_W'(RING_SLOTS - 1)) begin
         nxt = '0;
      end else begin
         nxt = slot + SLOT_W'(1);
      end
      return nxt;
   endfunction

endpackage

### rtl/rcbp_ring.sv
// free index ring: memory, head and tail pointers, level and fill count
`timescale 1ns / 1ps

module rcbp_ring (
   input  logic                   clock,
   input  logic                   reset,
   input  rcbp_pkg::ring_ctl_type ring_ctl,
   output rcbp_pkg::ring_stat_type ring_stat
);

   logic [rcbp_pkg::INDEX_W-1:0] ring_mem [rcbp_pkg::RING_SLOTS];

   logic [rcbp_pkg::SLOT_W-1:0]  head_ff, head_in;
   logic [rcbp_pkg::SLOT_W-1:0]  tail_ff, tail_in;
   logic [rcbp_pkg::LEVEL_W-1:0] level_ff, level_in;
   logic [rcbp_pkg::FILL_W-1:0]  fill_ff, fill_in;
   logic [rcbp_pkg::INDEX_W-1:0] rd_data_ff;
   logic [rcbp_pkg::SLOT_W-1:0]  rd_slot_ff;
   logic                         rd_written_ff;

   // pointer and level update
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      level_in = level_ff;
      fill_in  = fill_ff;
      if (ring_ctl.pop) begin
         head_in  = rcbp_pkg::next_slot(head_ff);
         level_in = level_ff - rcbp_pkg::LEVEL_W'(1);
      end
      if (ring_ctl.push) begin
         tail_in  = rcbp_pkg::next_slot(tail_ff);
         level_in = level_ff + rcbp_pkg::LEVEL_W'(1);
         // writes land in slot order starting at the reset tail
         if (fill_ff != rcbp_pkg::FILL_W'(rcbp_pkg::RING_SLOTS)) begin
            fill_in = fill_ff + rcbp_pkg::FILL_W'(1);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= rcbp_pkg::SLOT_W'(rcbp_pkg::BUF_COUNT);
         level_ff <= rcbp_pkg::LEVEL_W'(rcbp_pkg::BUF_COUNT);
         fill_ff  <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         level_ff <= level_in;
         fill_ff  <= fill_in;
      end
   end

   // ring memory, write at tail, registered read at head
   always_ff @(posedge clock) begin
      if (ring_ctl.push) begin
         ring_mem[tail_ff] <= ring_ctl.push_index;
      end
      rd_data_ff    <= ring_mem[head_ff];
      rd_slot_ff    <= head_ff;
      // slot s was written once (s + 1) mod slots is below the fill count
      rd_written_ff <= rcbp_pkg::FILL_W'(rcbp_pkg::next_slot(head_ff)) < fill_ff;
   end

   // a slot never written still holds its own index
   assign ring_stat.head_index = rd_written_ff ? rd_data_ff
                                               : rcbp_pkg::INDEX_W'(rd_slot_ff);
   assign ring_stat.level      = level_ff;

endmodule

### rtl/refcounted_buffer_pool.sv
// reference counted buffer pool: top level with count memory and control
//
// Usage: one request word on the req_ channel (kind in req_tuser, index and
// clear flag in req_tdata) gives exactly one response word on the rsp_
// channel (status in rsp_tuser, index, release flags and free count in
// rsp_tdata). Allocate hands out the oldest free index, free drops a
// reference and returns the index at zero if the ring is not full, share adds one.
// Flow: the accepting edge captures the request and reads its count;
// execute then decides and loads the response register once it is free.
// A new request is taken only in idle, after the read-modify-write of the
// count memory and the free ring, with one operation in flight at a time.
// Reset: the free ring holds every index 0..62 in order; a fill count
// stands in for its contents, so there is no clearing pass and a request
// can be taken in the first cycle after reset. Counts are undefined until
// an allocate writes them.
// Stall: a response waits in its register while rsp_tready is low; one more
// request is taken meanwhile and holds in execute until the register frees.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module refcounted_buffer_pool #(
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [5:0] buf_index, [6] clear_on_free, [7] zero
   input  logic [1:0]  req_tuser,   // [1:0] kind
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [5:0] buf_out, [6] released, [7] clear_request,
                                    // [13:8] free_count, [15:14] zero
   output logic [2:0]  rsp_tuser    // [2:0] status
);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;

   // captured request
   rcbp_pkg::kind_type            kind_ff;
   logic [rcbp_pkg::INDEX_W-1:0]  idx_ff;
   logic                          clr_ff;

   // response register
   logic                           rsp_valid_ff, rsp_valid_in;
   rcbp_pkg::status_type           status_ff, status_in;
   logic [rcbp_pkg::INDEX_W-1:0]   buf_out_ff, buf_out_in;
   logic                           released_ff, released_in;
   logic                           clear_req_ff, clear_req_in;
   logic [rcbp_pkg::LEVEL_W-1:0]   free_count_ff, free_count_in;

   // count memory
   logic [COUNT_BITS-1:0]          ref_mem [rcbp_pkg::BUF_COUNT];
   logic [COUNT_BITS-1:0]          ref_rd_ff;
   logic                           ref_we;
   logic [rcbp_pkg::REF_AW-1:0]    ref_waddr;
   logic [COUNT_BITS-1:0]          ref_wdata;

   rcbp_pkg::ring_ctl_type         ring_ctl;
   rcbp_pkg::ring_stat_type        ring_stat;

   logic                           req_accept;
   logic                           out_free;
   logic                           req_in_range;
   logic [COUNT_BITS-1:0]          count_dec;

   assign req_tready   = (state_ff == ST_IDLE);
   assign req_accept   = req_tvalid && req_tready;
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign req_in_range = req_tdata[rcbp_pkg::INDEX_W-1:0]
                         < rcbp_pkg::INDEX_W'(rcbp_pkg::BUF_COUNT);
   assign count_dec    = ref_rd_ff - COUNT_BITS'(1);

   rcbp_ring u_ring (
      .clock     (clock),
      .reset     (reset),
      .ring_ctl  (ring_ctl),
      .ring_stat (ring_stat)
   );

   // execute: decide the operation against the read count and ring head
   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      status_in     = status_ff;
      buf_out_in    = buf_out_ff;
      released_in   = released_ff;
      clear_req_in  = clear_req_ff;
      free_count_in = free_count_ff;
      ring_ctl      = '0;
      ref_we        = 1'b0;
      ref_waddr     = idx_ff[rcbp_pkg::REF_AW-1:0];
      ref_wdata     = ref_rd_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               status_in    = rcbp_pkg::STATUS_OK;
               buf_out_in   = idx_ff;
               released_in  = 1'b0;
               clear_req_in = 1'b0;
               unique case (kind_ff)
                  rcbp_pkg::KIND_ALLOC: begin
                     if (ring_stat.level == '0) begin
                        status_in  = rcbp_pkg::STATUS_EMPTY;
                        buf_out_in = '0;
                     end else begin
                        ring_ctl.pop = 1'b1;
                        buf_out_in   = ring_stat.head_index;
                        ref_waddr    = ring_stat.head_index[rcbp_pkg::REF_AW-1:0];
                        ref_wdata    = COUNT_BITS'(1);
                        ref_we       = ring_stat.head_index
                                       < rcbp_pkg::INDEX_W'(rcbp_pkg::BUF_COUNT);
                     end
                  end
                  rcbp_pkg::KIND_SHARE: begin
                     if (idx_ff >= rcbp_pkg::INDEX_W'(rcbp_pkg::BUF_COUNT)) begin
                        status_in = rcbp_pkg::STATUS_ZERO;
                     end else if (ref_rd_ff == COUNT_MAX) begin
                        status_in = rcbp_pkg::STATUS_SAT;
                     end else begin
                        ref_we    = 1'b1;
                        ref_wdata = ref_rd_ff + COUNT_BITS'(1);
                     end
                  end
                  rcbp_pkg::KIND_FREE: begin
                     if (idx_ff >= rcbp_pkg::INDEX_W'(rcbp_pkg::BUF_COUNT)) begin
                        status_in = rcbp_pkg::STATUS_ZERO;
                     end else if (ref_rd_ff == '0) begin
                        status_in = rcbp_pkg::STATUS_ZERO;
                     end else begin
                        ref_we    = 1'b1;
                        ref_wdata = count_dec;
                        if (count_dec != '0) begin
                           status_in = rcbp_pkg::STATUS_HELD;
                        end else if (ring_stat.level
                                     < rcbp_pkg::LEVEL_W'(rcbp_pkg::BUF_COUNT)) begin
                           // last reference gone, index back to the ring
                           ring_ctl.push       = 1'b1;
                           ring_ctl.push_index = idx_ff;
                           released_in         = 1'b1;
                           clear_req_in        = clr_ff;
                        end
                     end
                  end
                  default: begin
                     // unused kind does nothing
                  end
               endcase
               // ring level after this operation
               free_count_in = ring_stat.level;
               if (ring_ctl.pop) begin
                  free_count_in = ring_stat.level - rcbp_pkg::LEVEL_W'(1);
               end else if (ring_ctl.push) begin
                  free_count_in = ring_stat.level + rcbp_pkg::LEVEL_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff     <= status_in;
      buf_out_ff    <= buf_out_in;
      released_ff   <= released_in;
      clear_req_ff  <= clear_req_in;
      free_count_ff <= free_count_in;
   end

   // capture the request word
   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff <= rcbp_pkg::kind_type'(req_tuser);
         idx_ff  <= req_tdata[rcbp_pkg::INDEX_W-1:0];
         clr_ff  <= req_tdata[rcbp_pkg::INDEX_W];
      end
   end

   // count memory, registered read on accept, write back from execute
   always_ff @(posedge clock) begin
      if (req_accept && req_in_range) begin
         ref_rd_ff <= ref_mem[req_tdata[rcbp_pkg::REF_AW-1:0]];
      end
      if (ref_we) begin
         ref_mem[ref_waddr] <= ref_wdata;
      end
   end

   // response ports
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {2'b00, free_count_ff, clear_req_ff, released_ff, buf_out_ff};

   // checks
   `ASSERT_IMPLY(a_no_pop_and_push, clock, reset, ring_ctl.pop, !ring_ctl.push)
   `ASSERT_IMPLY(a_clear_needs_release, clock, reset, rsp_tvalid && rsp_tdata[7],
                 rsp_tdata[6] && (rsp_tuser == rcbp_pkg::STATUS_OK))
   `ASSERT_NEXT(a_level_idle_stable, clock, reset, state_ff == ST_IDLE,
                $stable(ring_stat.level))

endmodule

### tb/sv/refcounted_buffer_pool_checker.sv
// checker for the buffer pool: predicts each response word and compares it field by field
`timescale 1ns / 1ps

module refcounted_buffer_pool_checker #(
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [5:0] buf_index, [6] clear_on_free, [7] zero
   input  logic [1:0]  req_tuser,   // [1:0] kind
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [5:0] buf_out, [6] released, [7] clear_request,
                                    // [13:8] free_count, [15:14] zero
   input  logic [2:0]  rsp_tuser,   // [2:0] status
   output int          mismatches,
   output int          pending,
   output int          words_checked,
   output int          empty_hits,
   output int          sat_hits,
   output int          drop_hits,
   output int          clear_hits
);

   localparam logic [COUNT_BITS-1:0] REFS_MAX = '1;
   localparam int PRINT_CAP = 40;

   // one expected response word
   typedef struct packed {
      rcbp_pkg::status_type         status;
      logic [rcbp_pkg::INDEX_W-1:0] buf_out;
      logic                         released;
      logic                         clear_request;
      logic [rcbp_pkg::LEVEL_W-1:0] free_count;
   } pool_reply_type;

   // shadow copy of the pool
   logic [rcbp_pkg::INDEX_W-1:0] ring_slot [0:rcbp_pkg::RING_SLOTS-1];
   logic [rcbp_pkg::SLOT_W-1:0]  head_slot;
   logic [rcbp_pkg::SLOT_W-1:0]  tail_slot;
   logic [COUNT_BITS-1:0]        held_refs [0:rcbp_pkg::BUF_COUNT-1];

   pool_reply_type awaiting [$];

   initial begin
      mismatches    = 0;
      pending       = 0;
      words_checked = 0;
      empty_hits    = 0;
      sat_hits      = 0;
      drop_hits     = 0;
      clear_hits    = 0;
   end

   task automatic report_mismatch(input string msg);
      if (mismatches < PRINT_CAP) begin
         $display("%0t ns: response mismatch, %s", $time, msg);
      end
      mismatches++;
   endtask

   // apply one request word to the shadow pool and work out its response
   task automatic predict_word(input logic [rcbp_pkg::KIND_W-1:0] kind,
                               input logic [rcbp_pkg::INDEX_W-1:0] index,
                               input logic clear, output pool_reply_type rep);
      logic [rcbp_pkg::LEVEL_W-1:0] level;
      level             = tail_slot - head_slot;
      rep.status        = rcbp_pkg::STATUS_OK;
      rep.buf_out       = index;
      rep.released      = 1'b0;
      rep.clear_request = 1'b0;
      if (kind == rcbp_pkg::KIND_ALLOC) begin
         if (level == 0) begin
            rep.status  = rcbp_pkg::STATUS_EMPTY;
            rep.buf_out = '0;
         end else begin
            rep.buf_out = ring_slot[head_slot];
            if (rep.buf_out < rcbp_pkg::BUF_COUNT) begin
               held_refs[rep.buf_out] = COUNT_BITS'(1);
            end
            head_slot = head_slot + rcbp_pkg::SLOT_W'(1);
         end
      end else if (kind == rcbp_pkg::KIND_FREE || kind == rcbp_pkg::KIND_SHARE) begin
         if (index >= rcbp_pkg::BUF_COUNT) begin
            rep.status = rcbp_pkg::STATUS_ZERO;
         end else if (kind == rcbp_pkg::KIND_SHARE) begin
            if (held_refs[index] == REFS_MAX) begin
               rep.status = rcbp_pkg::STATUS_SAT;
            end else begin
               held_refs[index] = held_refs[index] + COUNT_BITS'(1);
            end
         end else if (held_refs[index] == 0) begin
            rep.status = rcbp_pkg::STATUS_ZERO;
         end else begin
            held_refs[index] = held_refs[index] - COUNT_BITS'(1);
            if (held_refs[index] != 0) begin
               rep.status = rcbp_pkg::STATUS_HELD;
            end else if (level < rcbp_pkg::BUF_COUNT) begin
               ring_slot[tail_slot] = index;
               tail_slot            = tail_slot + rcbp_pkg::SLOT_W'(1);
               rep.released         = 1'b1;
               rep.clear_request    = clear;
            end else begin
               // ring already full: index is dropped
               drop_hits++;
            end
         end
      end
      rep.free_count = tail_slot - head_slot;
   endtask

   // compare responses first, then predict the word accepted at this edge
   always @(posedge clock) begin : watch
      pool_reply_type rep;
      pool_reply_type want;
      if (reset) begin
         for (int i = 0; i < rcbp_pkg::RING_SLOTS; i++) begin
            ring_slot[i] = rcbp_pkg::INDEX_W'(i);
         end
         for (int i = 0; i < rcbp_pkg::BUF_COUNT; i++) begin
            held_refs[i] = '0;
         end
         head_slot = '0;
         tail_slot = rcbp_pkg::SLOT_W'(rcbp_pkg::BUF_COUNT);
         awaiting.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaiting.size() == 0) begin
               report_mismatch($sformatf("response word %h with nothing outstanding",
                                         rsp_tdata));
            end else begin
               want = awaiting.pop_front();
               words_checked++;
               if (rsp_tuser !== want.status)
                  report_mismatch($sformatf("status got %0d expected %0d",
                                            rsp_tuser, want.status));
               if (rsp_tdata[5:0] !== want.buf_out)
                  report_mismatch($sformatf("buf_out got %0d expected %0d",
                                            rsp_tdata[5:0], want.buf_out));
               if (rsp_tdata[6] !== want.released)
                  report_mismatch($sformatf("released got %b expected %b",
                                            rsp_tdata[6], want.released));
               if (rsp_tdata[7] !== want.clear_request)
                  report_mismatch($sformatf("clear_request got %b expected %b",
                                            rsp_tdata[7], want.clear_request));
               if (rsp_tdata[13:8] !== want.free_count)
                  report_mismatch($sformatf("free_count got %0d expected %0d",
                                            rsp_tdata[13:8], want.free_count));
            end
         end
         if (req_tvalid && req_tready) begin
            predict_word(req_tuser, req_tdata[5:0], req_tdata[6], rep);
            if (rep.status == rcbp_pkg::STATUS_EMPTY) empty_hits++;
            if (rep.status == rcbp_pkg::STATUS_SAT) sat_hits++;
            if (rep.clear_request) clear_hits++;
            awaiting.push_back(rep);
         end
      end
      pending = awaiting.size();
   end

endmodule

### tb/sv/refcounted_buffer_pool_test.sv
// testbench top for the buffer pool: clock, reset, request and response traffic, verdict
`timescale 1ns / 1ps

module refcounted_buffer_pool_test;

   localparam int COUNT_BITS   = 16;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int RANDOM_WORDS = 1320;
   localparam int PHASE_WORDS  = 120;
   localparam int SHARE_BURST  = 30;
   localparam int TAIL_CYCLES  = 20;
   localparam int SQUEEZE_HOLD = 300;
   localparam logic [rcbp_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam logic [rcbp_pkg::INDEX_W-1:0] OUT_OF_RANGE =
      rcbp_pkg::INDEX_W'(rcbp_pkg::BUF_COUNT);

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   int mismatches;
   int pending;
   int words_checked;
   int empty_hits;
   int sat_hits;
   int drop_hits;
   int clear_hits;

   int words_sent;
   int cycles;
   bit rush;
   bit squeeze_now;
   bit squeeze_done;

   // indices seen handed out by allocate, and those believed still referenced
   logic [rcbp_pkg::BUF_COUNT-1:0] ever;
   logic [rcbp_pkg::BUF_COUNT-1:0] live;
   logic [rcbp_pkg::KIND_W-1:0]    kinds_in_flight [$];

   refcounted_buffer_pool #(
      .COUNT_BITS(COUNT_BITS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   refcounted_buffer_pool_checker #(
      .COUNT_BITS(COUNT_BITS)
   ) watcher (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .mismatches   (mismatches),
      .pending      (pending),
      .words_checked(words_checked),
      .empty_hits   (empty_hits),
      .sat_hits     (sat_hits),
      .drop_hits    (drop_hits),
      .clear_hits   (clear_hits)
   );

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // run limit
   initial cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d words outstanding", cycles, pending);
         $display("Some tests failed");
         $finish;
      end
   end

   // follow responses to learn which indices may be freed or shared
   initial begin
      ever = '0;
      live = '0;
   end
   always @(posedge clock) begin : track
      logic [rcbp_pkg::KIND_W-1:0]   k;
      logic [rcbp_pkg::INDEX_W-1:0]  b;
      logic [rcbp_pkg::STATUS_W-1:0] st;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready && kinds_in_flight.size() > 0) begin
            k  = kinds_in_flight.pop_front();
            b  = rsp_tdata[5:0];
            st = rsp_tuser;
            if (b < rcbp_pkg::BUF_COUNT) begin
               if (k == rcbp_pkg::KIND_ALLOC && st == rcbp_pkg::STATUS_OK) begin
                  ever[b] = 1'b1;
                  live[b] = 1'b1;
               end else if (k == rcbp_pkg::KIND_FREE && st != rcbp_pkg::STATUS_HELD) begin
                  live[b] = 1'b0;
               end else if (k == rcbp_pkg::KIND_SHARE &&
                            (st == rcbp_pkg::STATUS_OK || st == rcbp_pkg::STATUS_SAT)) begin
                  live[b] = 1'b1;
               end
            end
         end
         if (req_tvalid && req_tready) kinds_in_flight.push_back(req_tuser);
      end
   end

   // response side: random stalls, one long hold-off, always ready during the ramp
   initial begin : receiver
      int r;
      int run;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rush) begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end else if (squeeze_now && !squeeze_done) begin
            rsp_tready <= 1'b0;
            repeat (SQUEEZE_HOLD) @(negedge clock);
            squeeze_done = 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 25) begin
               rsp_tready <= 1'b1;
               run = $urandom_range(10, 60);
            end else if (r < 75) begin
               rsp_tready <= 1'b1;
               run = $urandom_range(1, 4);
            end else if (r < 95) begin
               rsp_tready <= 1'b0;
               run = $urandom_range(1, 4);
            end else begin
               rsp_tready <= 1'b0;
               run = $urandom_range(15, 50);
            end
            repeat (run) @(negedge clock);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // offer one request word, called at a falling edge, returns at a falling edge
   task automatic offer_word(input logic [rcbp_pkg::KIND_W-1:0] kind,
                             input logic [rcbp_pkg::INDEX_W-1:0] index,
                             input logic clear, input bit paced);
      int gap;
      gap = paced ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {1'b0, clear, index};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
      @(negedge clock);
   endtask

   // one random word; bias 0 leans to allocate, 1 to free, 2 is balanced
   task automatic random_word(input int bias, input bit paced);
      int r;
      int alloc_pct;
      int live_list [$];
      int ever_list [$];
      logic [rcbp_pkg::KIND_W-1:0]  kind;
      logic [rcbp_pkg::INDEX_W-1:0] index;
      for (int i = 0; i < rcbp_pkg::BUF_COUNT; i++) begin
         if (live[i]) live_list.push_back(i);
         if (ever[i]) ever_list.push_back(i);
      end
      alloc_pct = (bias == 0) ? 80 : (bias == 1) ? 15 : 45;
      r         = $urandom_range(0, 99);
      index     = rcbp_pkg::INDEX_W'($urandom_range(0, 63));
      if (r < 2) begin
         kind = KIND_UNUSED;
      end else if (r < 5) begin
         kind  = ($urandom_range(0, 1) != 0) ? rcbp_pkg::KIND_FREE : rcbp_pkg::KIND_SHARE;
         index = OUT_OF_RANGE;
      end else if (r < 5 + alloc_pct || ever_list.size() == 0) begin
         kind = rcbp_pkg::KIND_ALLOC;
      end else begin
         kind = ($urandom_range(0, 99) < ((bias == 1) ? 80 : 65)) ? rcbp_pkg::KIND_FREE
                                                                   : rcbp_pkg::KIND_SHARE;
         // mostly referenced buffers, sometimes ones already back in the ring
         if (live_list.size() > 0 && $urandom_range(0, 9) < 8) begin
            index = rcbp_pkg::INDEX_W'(live_list[$urandom_range(0, live_list.size() - 1)]);
         end else begin
            index = rcbp_pkg::INDEX_W'(ever_list[$urandom_range(0, ever_list.size() - 1)]);
         end
      end
      offer_word(kind, index, 1'($urandom_range(0, 1)), paced);
   endtask

   // stimulus and verdict
   initial begin : stimulus
      int sent;
      int bias;
      bit steady;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      words_sent   = 0;
      rush         = 1'b0;
      squeeze_now  = 1'b0;
      squeeze_done = 1'b0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // directed: every operation and the corner cases around one buffer
      offer_word(rcbp_pkg::KIND_ALLOC, 6'd45, 1'b1, 1'b1);  // hands out 0
      offer_word(rcbp_pkg::KIND_SHARE, 6'd0, 1'b0, 1'b1);   // two references
      offer_word(rcbp_pkg::KIND_FREE, 6'd0, 1'b1, 1'b1);    // still referenced
      offer_word(rcbp_pkg::KIND_FREE, 6'd0, 1'b1, 1'b1);    // released with clear, ring full again
      offer_word(rcbp_pkg::KIND_FREE, 6'd0, 1'b1, 1'b1);    // count already zero
      offer_word(rcbp_pkg::KIND_SHARE, 6'd0, 1'b0, 1'b1);   // share from zero
      offer_word(rcbp_pkg::KIND_FREE, 6'd0, 1'b1, 1'b1);    // ring full, index dropped
      offer_word(rcbp_pkg::KIND_FREE, OUT_OF_RANGE, 1'b1, 1'b1);
      offer_word(rcbp_pkg::KIND_SHARE, OUT_OF_RANGE, 1'b1, 1'b1);
      offer_word(KIND_UNUSED, 6'd42, 1'b1, 1'b1);           // no-op
      offer_word(rcbp_pkg::KIND_ALLOC, 6'd63, 1'b0, 1'b1);  // hands out 1
      offer_word(rcbp_pkg::KIND_FREE, 6'd1, 1'b0, 1'b1);    // released without clear
      offer_word(rcbp_pkg::KIND_ALLOC, 6'd63, 1'b0, 1'b1);  // hands out 2

      // back to back shares on buffer 2, then as many frees back to one reference
      rush = 1'b1;
      repeat (SHARE_BURST)
         offer_word(rcbp_pkg::KIND_SHARE, 6'd2, 1'($urandom_range(0, 1)), 1'b0);
      repeat (SHARE_BURST) offer_word(rcbp_pkg::KIND_FREE, 6'd2, 1'b1, 1'b0);
      rush = 1'b0;

      // random phases, the first one starting under a long response hold-off
      squeeze_now = 1'b1;
      sent        = 0;
      while (sent < RANDOM_WORDS) begin
         bias   = $urandom_range(0, 2);
         steady = ($urandom_range(0, 3) == 0);
         repeat (PHASE_WORDS) begin
            random_word(bias, !steady);
            sent++;
         end
      end
      req_tvalid <= 1'b0;

      // drain
      while (pending != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("%0d request words sent, %0d responses checked, %0d mismatches",
               words_sent, words_checked, mismatches);
      $display("pool empty %0d times, %0d saturated shares, %0d full-ring drops, %0d clears",
               empty_hits, sat_hits, drop_hits, clear_hits);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
